[rtl/core/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg: CP15 register map
// Shared types, constants and the selector decode for the coprocessor-15
// register file.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  localparam int NumWords = 28;
  localparam int WordIdxW = $clog2(NumWords);

  // access rights, one bit per direction and privilege level
  localparam logic [3:0] ACC_RP = 4'b0001;
  localparam logic [3:0] ACC_RU = 4'b0010;
  localparam logic [3:0] ACC_WP = 4'b0100;
  localparam logic [3:0] ACC_WU = 4'b1000;

  localparam logic [0:0] CFG_CACHE_TYPE = 1'b0;
  localparam logic [0:0] CFG_CPU_ID     = 1'b1;

  typedef enum logic [1:0] {
    KIND_STATE,
    KIND_CONST,
    KIND_CFG,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    logic                found;
    kind_t               kind;
    logic [WordIdxW-1:0] idx;
    logic [3:0]          acc;
    logic [31:0]         value;
  } map_entry_t;

  localparam logic [31:0] WORD_RESET [NumWords] = '{
    32'h0005_4078, 32'h0000_000F, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFF0, 32'h0, 32'h0009_8AA4,
    32'h44E0_48E0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
  };

  function automatic logic [13:0] sel(input int unsigned c, input int unsigned a,
                                      input int unsigned m, input int unsigned b);
    return {4'(c), 3'(a), 4'(m), 3'(b)};
  endfunction

  function automatic map_entry_t mk(input kind_t k, input int unsigned i,
                                    input logic [3:0] acc, input logic [31:0] v);
    map_entry_t e;
    e.found = 1'b1;
    e.kind  = k;
    e.idx   = WordIdxW'(i);
    e.acc   = acc;
    e.value = v;
    return e;
  endfunction

  // Map lookup: CRn, Op1, CRm, Op2 to the implemented register, if any.
  function automatic map_entry_t decode(input logic [3:0] crn, input logic [2:0] op1,
                                        input logic [3:0] crm, input logic [2:0] op2);
    map_entry_t e;
    logic [13:0] key;
    e   = '0;
    key = {crn, op1, crm, op2};
    // main TLB lockdown entry operations
    if (crn == 4'd8 && op1 == 3'd0 && crm >= 4'd5 && crm <= 4'd7 && op2 <= 3'd3) begin
      e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
    end else begin
      case (key)
        sel(0, 0, 0, 0):  e = mk(KIND_CONST, 0, ACC_RP, 32'h410F_B024);
        sel(0, 0, 0, 1):  e = mk(KIND_CFG, 0, ACC_RP, 32'h0);
        sel(0, 0, 0, 3):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0000_0800);
        sel(0, 0, 0, 5):  e = mk(KIND_CFG, 1, ACC_RP, 32'h0);
        sel(0, 0, 1, 0):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0000_0111);
        sel(0, 0, 1, 1):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0000_0001);
        sel(0, 0, 1, 2):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0000_0002);
        sel(0, 0, 1, 4):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0110_0103);
        sel(0, 0, 1, 5):  e = mk(KIND_CONST, 0, ACC_RP, 32'h1002_0302);
        sel(0, 0, 1, 6):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0122_2000);
        sel(0, 0, 1, 7):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0);
        sel(0, 0, 2, 0):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0010_0011);
        sel(0, 0, 2, 1):  e = mk(KIND_CONST, 0, ACC_RP, 32'h1200_2111);
        sel(0, 0, 2, 2):  e = mk(KIND_CONST, 0, ACC_RP, 32'h1122_1011);
        sel(0, 0, 2, 3):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0110_2131);
        sel(0, 0, 2, 4):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0000_0141);
        sel(1, 0, 0, 0):  e = mk(KIND_STATE, 0, ACC_RP | ACC_WP, 32'h0);
        sel(1, 0, 0, 1):  e = mk(KIND_STATE, 1, ACC_RP | ACC_WP, 32'h0);
        sel(1, 0, 0, 2):  e = mk(KIND_STATE, 2, ACC_RP | ACC_WP, 32'h0);
        sel(2, 0, 0, 0):  e = mk(KIND_STATE, 3, ACC_RP | ACC_WP, 32'h0);
        sel(2, 0, 0, 1):  e = mk(KIND_STATE, 4, ACC_RP | ACC_WP, 32'h0);
        sel(2, 0, 0, 2):  e = mk(KIND_STATE, 5, ACC_RP | ACC_WP, 32'h0);
        sel(3, 0, 0, 0):  e = mk(KIND_STATE, 6, ACC_RP | ACC_WP, 32'h0);
        sel(5, 0, 0, 0):  e = mk(KIND_STATE, 7, ACC_RP | ACC_WP, 32'h0);
        sel(5, 0, 0, 1):  e = mk(KIND_STATE, 8, ACC_RP | ACC_WP, 32'h0);
        sel(6, 0, 0, 0):  e = mk(KIND_STATE, 9, ACC_RP | ACC_WP, 32'h0);
        sel(6, 0, 0, 1):  e = mk(KIND_STATE, 10, ACC_RP | ACC_WP, 32'h0);
        sel(7, 0, 4, 0):  e = mk(KIND_CONST, 0, ACC_RP, 32'h0);
        sel(7, 0, 0, 4):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 5, 0):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 5, 1):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 5, 2):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 5, 4):  e = mk(KIND_NOP, 0, ACC_WP | ACC_WU, 32'h0);
        sel(7, 0, 5, 6):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 5, 7):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 6, 0):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 6, 1):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 6, 2):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 7, 0):  e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 10, 0): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 10, 1): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 10, 2): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 10, 4): e = mk(KIND_NOP, 0, ACC_WP | ACC_WU, 32'h0);
        sel(7, 0, 10, 5): e = mk(KIND_NOP, 0, ACC_WP | ACC_WU, 32'h0);
        sel(7, 0, 14, 0): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 14, 1): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(7, 0, 14, 2): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(9, 0, 0, 0):  e = mk(KIND_STATE, 11, ACC_RP | ACC_WP, 32'h0);
        sel(10, 0, 0, 0): e = mk(KIND_STATE, 12, ACC_RP | ACC_WP, 32'h0);
        sel(10, 0, 2, 0): e = mk(KIND_STATE, 13, ACC_RP | ACC_WP, 32'h0);
        sel(10, 0, 2, 1): e = mk(KIND_STATE, 14, ACC_RP | ACC_WP, 32'h0);
        sel(13, 0, 0, 0): e = mk(KIND_STATE, 15, ACC_RP | ACC_WP, 32'h0);
        sel(13, 0, 0, 1): e = mk(KIND_STATE, 16, ACC_RP | ACC_WP, 32'h0);
        sel(13, 0, 0, 2): e = mk(KIND_STATE, 17, ACC_RP | ACC_RU | ACC_WP | ACC_WU, 32'h0);
        sel(13, 0, 0, 3): e = mk(KIND_STATE, 18, ACC_RP | ACC_RU | ACC_WP, 32'h0);
        sel(13, 0, 0, 4): e = mk(KIND_STATE, 19, ACC_RP | ACC_WP, 32'h0);
        sel(15, 0, 12, 0): e = mk(KIND_STATE, 20, ACC_RP | ACC_WP, 32'h0);
        sel(15, 0, 12, 1): e = mk(KIND_STATE, 21, ACC_RP | ACC_WP, 32'h0);
        sel(15, 0, 12, 2): e = mk(KIND_STATE, 22, ACC_RP | ACC_WP, 32'h0);
        sel(15, 0, 12, 3): e = mk(KIND_STATE, 23, ACC_RP | ACC_WP, 32'h0);
        sel(15, 5, 4, 2): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(15, 5, 4, 4): e = mk(KIND_NOP, 0, ACC_WP, 32'h0);
        sel(15, 5, 5, 2): e = mk(KIND_STATE, 24, ACC_RP | ACC_WP, 32'h0);
        sel(15, 5, 6, 2): e = mk(KIND_STATE, 25, ACC_RP | ACC_WP, 32'h0);
        sel(15, 5, 7, 2): e = mk(KIND_STATE, 26, ACC_RP | ACC_WP, 32'h0);
        sel(15, 7, 1, 0): e = mk(KIND_STATE, 27, ACC_RP | ACC_WP, 32'h0);
        default:          e = '0;
      endcase
    end
    return e;
  endfunction

endpackage

`default_nettype wire

[rtl/core/system_control_coprocessor_regs.sv]
// ----------------------------------------------------------------------------
// system_control_coprocessor_regs: CP15 system control register file
// MRC/MCR access port over the control, translation, fault, lockdown,
// remap, thread-ID and performance-counter words of the core.
// ----------------------------------------------------------------------------
`default_nettype none

// One access per beat: the block takes a new access every cycle while the result
// side is not stalled, and returns one result beat per access. An access sits in
// the input register, where the selector is decoded and the register file is
// read or written, until the result register is free; the result register then
// holds read_data and recognized until taken. Writes commit as the access leaves
// the input register, so a read that follows a write in the next beat already
// sees the new value. Write accesses return read_data zero.
// Accesses that match no implemented register, or that the current privilege
// may not make in that direction, return recognized low and change nothing.
// Cache type and CPU ID are taken from the cfg_ port (index 0 and 1), which
// may be written only while no access is in flight.
module system_control_coprocessor_regs
  import scc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // access channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic        in_privileged,
  input  wire logic [3:0]  in_crn_field,
  input  wire logic [2:0]  in_op1_field,
  input  wire logic [3:0]  in_crm_field,
  input  wire logic [2:0]  in_op2_field,
  input  wire logic [31:0] in_write_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data,
  output logic             out_recognized,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_write_r;
  logic        s1_priv_r;
  logic [3:0]  s1_crn_r;
  logic [2:0]  s1_op1_r;
  logic [3:0]  s1_crm_r;
  logic [2:0]  s1_op2_r;
  logic [31:0] s1_wval_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_hit_r, out_hit_nxt;

  // register file and config words
  logic [31:0] words_r [NumWords];
  logic [31:0] cache_type_r;
  logic [31:0] cpu_id_r;

  logic        in_fire;
  logic        s1_adv;
  logic        s1_fire;
  logic [2:0]  op1_eff;
  logic [3:0]  need;
  map_entry_t  ent;
  logic        hit;
  logic        word_we;

  // handshake: the result register frees up when taken, the input register
  // when its beat moves on
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && s1_adv;

  always_comb begin
    // privileged CRn 13 reads of PID, context ID and PRW ignore Op1
    op1_eff = s1_op1_r;
    if (!s1_write_r && s1_priv_r && s1_crn_r == 4'd13 && s1_crm_r == 4'd0 &&
        (s1_op2_r == 3'd0 || s1_op2_r == 3'd1 || s1_op2_r == 3'd4)) begin
      op1_eff = 3'd0;
    end

    if (s1_write_r) begin
      need = s1_priv_r ? ACC_WP : ACC_WU;
    end else begin
      need = s1_priv_r ? ACC_RP : ACC_RU;
    end

    ent     = decode(s1_crn_r, op1_eff, s1_crm_r, s1_op2_r);
    hit     = ent.found && ((ent.acc & need) != 4'd0);
    word_we = s1_fire && hit && s1_write_r && ent.kind == KIND_STATE;

    out_data_nxt = out_data_r;
    out_hit_nxt  = out_hit_r;
    if (s1_fire) begin
      out_hit_nxt  = hit;
      out_data_nxt = 32'h0;
      if (hit && !s1_write_r) begin
        unique case (ent.kind)
          KIND_STATE: out_data_nxt = words_r[ent.idx];
          KIND_CONST: out_data_nxt = ent.value;
          KIND_CFG:   out_data_nxt = (ent.idx[0] == CFG_CPU_ID) ? cpu_id_r : cache_type_r;
          KIND_NOP:   out_data_nxt = 32'h0;
        endcase
      end
    end

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state, register file and config words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      cache_type_r <= 32'h0;
      cpu_id_r     <= 32'h0;
      for (int i = 0; i < NumWords; i++) begin
        words_r[i] <= WORD_RESET[i];
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (word_we) begin
        words_r[ent.idx] <= s1_wval_r;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_CPU_ID) begin
          cpu_id_r <= cfg_wdata;
        end else begin
          cache_type_r <= cfg_wdata;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_write_r <= in_opcode;
      s1_priv_r  <= in_privileged;
      s1_crn_r   <= in_crn_field;
      s1_op1_r   <= in_op1_field;
      s1_crm_r   <= in_crm_field;
      s1_op2_r   <= in_op2_field;
      s1_wval_r  <= in_write_value;
    end
    out_data_r <= out_data_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_recognized = out_hit_r;

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: CP15 system control register file
// Drives MRC/MCR access beats into system_control_coprocessor_regs and checks every
// result beat against a local predictor of the register map or a typed-in answer,
// with random idle cycles on the access side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import scc_pkg::*;

  // Access kinds carried on in_opcode
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int WordCount  = 28;
  localparam int PhaseItems = 260;   // random beats per register setting
  localparam int IdleLimit  = 1000;  // cycles without any handshake

  // One coprocessor access, laid out in port order
  typedef struct packed {
    logic        op;
    logic        priv;
    logic [3:0]  crn;
    logic [2:0]  op1;
    logic [3:0]  crm;
    logic [2:0]  op2;
    logic [31:0] wval;
  } access_t;

  typedef struct packed {
    logic [31:0] data;
    logic        hit;
  } result_t;

  // Typed-in answer for a directed row; typed low means the predictor decides
  typedef struct packed {
    logic    typed;
    result_t want;
  } tag_t;

  typedef struct packed {
    access_t beat;
    tag_t    tag;
  } row_t;

  // What a selector decodes to in the predictor's own map
  typedef struct packed {
    logic        found;
    kind_t       kind;
    logic [4:0]  idx;
    logic [3:0]  acc;
    logic [31:0] value;
  } reg_slot_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        in_opcode      = 1'b0;
  logic        in_privileged  = 1'b0;
  logic [3:0]  in_crn_field   = '0;
  logic [2:0]  in_op1_field   = '0;
  logic [3:0]  in_crm_field   = '0;
  logic [2:0]  in_op2_field   = '0;
  logic [31:0] in_write_value = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] out_read_data;
  logic        out_recognized;
  logic        cfg_we         = 1'b0;
  logic [0:0]  cfg_index      = CFG_CACHE_TYPE;
  logic [31:0] cfg_wdata      = '0;

  system_control_coprocessor_regs dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_privileged  (in_privileged),
    .in_crn_field   (in_crn_field),
    .in_op1_field   (in_op1_field),
    .in_crm_field   (in_crm_field),
    .in_op2_field   (in_op2_field),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_recognized (out_recognized),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: writable words plus the two ID words from the cfg port
  // --------------------------------------------------------------------------
  logic [31:0] cp15_words [WordCount];
  logic [31:0] cache_type_q;
  logic [31:0] cpu_id_q;

  result_t expected_results [$];  // one per accepted access, oldest first
  tag_t    directed_answers [$];  // one per access put on the bus

  int mismatches = 0;
  int n_reads    = 0;
  int n_writes   = 0;
  int n_user     = 0;
  int n_hits     = 0;
  int n_settings = 0;

  task automatic reset_shadow();
    foreach (cp15_words[i]) cp15_words[i] = 32'h0;
    cp15_words[0]  = 32'h0005_4078;  // control
    cp15_words[1]  = 32'h0000_000F;  // auxiliary control
    cp15_words[11] = 32'hFFFF_FFF0;  // data cache lockdown
    cp15_words[13] = 32'h0009_8AA4;  // primary region remap
    cp15_words[14] = 32'h44E0_48E0;  // normal region remap
    cache_type_q = 32'h0;
    cpu_id_q     = 32'h0;
  endtask

  function automatic reg_slot_t hit_slot(input kind_t kind, input int idx,
                                         input logic [3:0] acc, input logic [31:0] value);
    reg_slot_t s;
    s.found = 1'b1;
    s.kind  = kind;
    s.idx   = 5'(idx);
    s.acc   = acc;
    s.value = value;
    return s;
  endfunction

  // Register map, organized by CRn; lo is {CRm, Op2}
  function automatic reg_slot_t find_slot(input logic [3:0] crn, input logic [2:0] op1,
                                          input logic [3:0] crm, input logic [2:0] op2);
    reg_slot_t s;
    logic [6:0] lo;
    s  = '0;
    lo = {crm, op2};
    case (crn)
      4'd0: begin
        if (op1 == 3'd0) begin
          case (lo)
            {4'd0, 3'd0}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h410F_B024);
            {4'd0, 3'd1}: s = hit_slot(KIND_CFG, 0, ACC_RP, 32'h0);
            {4'd0, 3'd3}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0000_0800);
            {4'd0, 3'd5}: s = hit_slot(KIND_CFG, 1, ACC_RP, 32'h0);
            {4'd1, 3'd0}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0000_0111);
            {4'd1, 3'd1}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0000_0001);
            {4'd1, 3'd2}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0000_0002);
            {4'd1, 3'd4}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0110_0103);
            {4'd1, 3'd5}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h1002_0302);
            {4'd1, 3'd6}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0122_2000);
            {4'd1, 3'd7}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0);
            {4'd2, 3'd0}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0010_0011);
            {4'd2, 3'd1}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h1200_2111);
            {4'd2, 3'd2}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h1122_1011);
            {4'd2, 3'd3}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0110_2131);
            {4'd2, 3'd4}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0000_0141);
            default: ;
          endcase
        end
      end
      // control, translation base and domain words
      4'd1: if (op1 == 3'd0 && crm == 4'd0 && op2 <= 3'd2)
              s = hit_slot(KIND_STATE, int'(op2), ACC_RP | ACC_WP, 32'h0);
      4'd2: if (op1 == 3'd0 && crm == 4'd0 && op2 <= 3'd2)
              s = hit_slot(KIND_STATE, 3 + op2, ACC_RP | ACC_WP, 32'h0);
      4'd3: if (op1 == 3'd0 && crm == 4'd0 && op2 == 3'd0)
              s = hit_slot(KIND_STATE, 6, ACC_RP | ACC_WP, 32'h0);
      // fault status and fault address
      4'd5: if (op1 == 3'd0 && crm == 4'd0 && op2 <= 3'd1)
              s = hit_slot(KIND_STATE, 7 + op2, ACC_RP | ACC_WP, 32'h0);
      4'd6: if (op1 == 3'd0 && crm == 4'd0 && op2 <= 3'd1)
              s = hit_slot(KIND_STATE, 9 + op2, ACC_RP | ACC_WP, 32'h0);
      4'd7: begin
        if (op1 == 3'd0) begin
          case (lo)
            {4'd4, 3'd0}: s = hit_slot(KIND_CONST, 0, ACC_RP, 32'h0);
            // barriers and prefetch flush are also open to user mode
            {4'd5, 3'd4}, {4'd10, 3'd4}, {4'd10, 3'd5}:
              s = hit_slot(KIND_NOP, 0, ACC_WP | ACC_WU, 32'h0);
            {4'd0, 3'd4}, {4'd5, 3'd0}, {4'd5, 3'd1}, {4'd5, 3'd2}, {4'd5, 3'd6},
            {4'd5, 3'd7}, {4'd6, 3'd0}, {4'd6, 3'd1}, {4'd6, 3'd2}, {4'd7, 3'd0},
            {4'd10, 3'd0}, {4'd10, 3'd1}, {4'd10, 3'd2}, {4'd14, 3'd0},
            {4'd14, 3'd1}, {4'd14, 3'd2}:
              s = hit_slot(KIND_NOP, 0, ACC_WP, 32'h0);
            default: ;
          endcase
        end
      end
      // TLB lockdown entry operations
      4'd8: if (op1 == 3'd0 && crm >= 4'd5 && crm <= 4'd7 && op2 <= 3'd3)
              s = hit_slot(KIND_NOP, 0, ACC_WP, 32'h0);
      4'd9: if (op1 == 3'd0 && lo == {4'd0, 3'd0})
              s = hit_slot(KIND_STATE, 11, ACC_RP | ACC_WP, 32'h0);
      4'd10: begin
        if (op1 == 3'd0) begin
          case (lo)
            {4'd0, 3'd0}: s = hit_slot(KIND_STATE, 12, ACC_RP | ACC_WP, 32'h0);
            {4'd2, 3'd0}: s = hit_slot(KIND_STATE, 13, ACC_RP | ACC_WP, 32'h0);
            {4'd2, 3'd1}: s = hit_slot(KIND_STATE, 14, ACC_RP | ACC_WP, 32'h0);
            default: ;
          endcase
        end
      end
      // PID, context ID, thread URW / URO / PRW
      4'd13: begin
        if (op1 == 3'd0 && crm == 4'd0 && op2 <= 3'd4) begin
          case (op2)
            3'd2:    s = hit_slot(KIND_STATE, 17, ACC_RP | ACC_RU | ACC_WP | ACC_WU, 32'h0);
            3'd3:    s = hit_slot(KIND_STATE, 18, ACC_RP | ACC_RU | ACC_WP, 32'h0);
            default: s = hit_slot(KIND_STATE, 15 + op2, ACC_RP | ACC_WP, 32'h0);
          endcase
        end
      end
      4'd15: begin
        case (op1)
          3'd0: if (crm == 4'd12 && op2 <= 3'd3)
                  s = hit_slot(KIND_STATE, 20 + op2, ACC_RP | ACC_WP, 32'h0);
          3'd5: begin
            case (lo)
              {4'd4, 3'd2}, {4'd4, 3'd4}: s = hit_slot(KIND_NOP, 0, ACC_WP, 32'h0);
              {4'd5, 3'd2}: s = hit_slot(KIND_STATE, 24, ACC_RP | ACC_WP, 32'h0);
              {4'd6, 3'd2}: s = hit_slot(KIND_STATE, 25, ACC_RP | ACC_WP, 32'h0);
              {4'd7, 3'd2}: s = hit_slot(KIND_STATE, 26, ACC_RP | ACC_WP, 32'h0);
              default: ;
            endcase
          end
          3'd7: if (lo == {4'd1, 3'd0})
                  s = hit_slot(KIND_STATE, 27, ACC_RP | ACC_WP, 32'h0);
          default: ;
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

  // Works out the result of one access and commits any register write
  function automatic result_t predict_access(input access_t a);
    result_t    r;
    reg_slot_t  s;
    logic [2:0] op1;
    logic [3:0] need;
    r   = '0;
    op1 = a.op1;
    // privileged reads of PID, context ID and thread PRW don't decode Op1
    if (a.op == OP_READ && a.priv && a.crn == 4'd13 && a.crm == 4'd0 &&
        (a.op2 == 3'd0 || a.op2 == 3'd1 || a.op2 == 3'd4))
      op1 = 3'd0;
    if (a.op == OP_WRITE) need = a.priv ? ACC_WP : ACC_WU;
    else                  need = a.priv ? ACC_RP : ACC_RU;
    s = find_slot(a.crn, op1, a.crm, a.op2);
    if (s.found && (s.acc & need) != 4'b0) begin
      r.hit = 1'b1;
      if (a.op == OP_WRITE) begin
        if (s.kind == KIND_STATE) cp15_words[s.idx] = a.wval;
      end else begin
        case (s.kind)
          KIND_STATE: r.data = cp15_words[s.idx];
          KIND_CONST: r.data = s.value;
          KIND_CFG:   r.data = (s.idx == 5'd0) ? cache_type_q : cpu_id_q;
          default:    r.data = 32'h0;
        endcase
      end
    end
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] MISMATCH %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus helpers
  // --------------------------------------------------------------------------
  // Idle length: mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_word();
    int k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << k;
      3:       return ~(32'h1 << k);
      default: return $urandom;
    endcase
  endfunction

  // 70% mapped selectors, 15% mapped with one field knocked off, 15% noise
  function automatic access_t random_access();
    access_t   a;
    reg_slot_t s;
    int        mode;
    a.op   = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
    a.priv = ($urandom_range(0, 3) != 0);
    a.wval = random_word();
    mode   = $urandom_range(0, 99);
    if (mode < 85) begin
      if (!a.priv && $urandom_range(0, 1) == 0) begin
        // user mode mostly lands on nothing; steer half of it to thread IDs
        a.crn = 4'd13;
        a.op1 = 3'd0;
        a.crm = 4'd0;
        a.op2 = 3'($urandom_range(2, 3));
      end else begin
        do begin
          a.crn = 4'($urandom);
          a.op1 = ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'd0;
          a.crm = 4'($urandom);
          a.op2 = 3'($urandom);
          s = find_slot(a.crn, a.op1, a.crm, a.op2);
        end while (!s.found);
      end
      if (mode >= 70) begin
        case ($urandom_range(0, 3))
          0:       a.crn = 4'($urandom);
          1:       a.op1 = 3'($urandom);
          2:       a.crm = 4'($urandom);
          default: a.op2 = 3'($urandom);
        endcase
      end else if (a.crn == 4'd13 && $urandom_range(0, 1) == 0) begin
        // probe the Op1 don't-care on CRn 13
        a.op1 = 3'($urandom);
      end
    end else begin
      a.crn = 4'($urandom);
      a.op1 = 3'($urandom);
      a.crm = 4'($urandom);
      a.op2 = 3'($urandom);
    end
    return a;
  endfunction

  function automatic row_t mk_row(input logic op, input logic priv, input int crn,
                                  input int op1, input int crm, input int op2,
                                  input logic [31:0] wval, input logic typed,
                                  input logic [31:0] data, input logic hit);
    row_t r;
    r.beat = {op, priv, 4'(crn), 3'(op1), 4'(crm), 3'(op2), wval};
    r.tag  = {typed, data, hit};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Bus drivers. All called at a rising edge; drive with NBAs only.
  // --------------------------------------------------------------------------
  // Puts one access beat up after an idle gap and holds it until taken.
  // With no gap, valid simply stays high and the payload moves on.
  task automatic issue_access(input access_t a, input int gap, input tag_t tag);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= a.op;
    in_privileged  <= a.priv;
    in_crn_field   <= a.crn;
    in_op1_field   <= a.op1;
    in_crm_field   <= a.crm;
    in_op2_field   <= a.op2;
    in_write_value <= a.wval;
    directed_answers.push_back(tag);
    do @(posedge clk); while (!in_ready);
  endtask

  // Both ID words in back-to-back cycles; we stays high across the pair
  task automatic load_id_regs(input logic [31:0] cache_type, input logic [31:0] cpu_id);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CACHE_TYPE;
    cfg_wdata <= cache_type;
    @(posedge clk);
    cfg_index <= CFG_CPU_ID;
    cfg_wdata <= cpu_id;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cache_type_q  = cache_type;
    cpu_id_q      = cpu_id;
    n_settings++;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe settle.
  // The first edge lets the monitor log the last accepted beat.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side back-pressure: ready runs of random length, stalls between
  // them drawn like the access gaps (often none, a few long)
  // --------------------------------------------------------------------------
  initial begin : result_pacing
    int run;
    int stall;
    forever begin
      run   = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
      stall = pick_gap();
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Beat monitor: predicts on every accepted access, checks every result
  // beat against the oldest prediction. Sampled at the edge, so it sees the
  // values from before this edge's NBAs.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    access_t seen;
    result_t want;
    tag_t    tag;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen = {in_opcode, in_privileged, in_crn_field, in_op1_field, in_crm_field,
                in_op2_field, in_write_value};
        want = predict_access(seen);
        tag  = directed_answers.pop_front();
        if (tag.typed) want = tag.want;
        expected_results.push_back(want);
        if (seen.op == OP_WRITE) n_writes++;
        else                     n_reads++;
        if (!seen.priv) n_user++;
        if (want.hit) n_hits++;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result beat with no access pending", 32'h0, out_read_data);
        end else begin
          want = expected_results.pop_front();
          if (out_read_data !== want.data)
            flag_mismatch("read_data", want.data, out_read_data);
          if (out_recognized !== want.hit)
            flag_mismatch("recognized", 32'(want.hit), 32'(out_recognized));
        end
      end
    end
  end

  // Watchdog: any stretch this long with no beat on either side is a hang
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("[%0t] no handshake for %0d cycles, %0d results outstanding", $time,
             IdleLimit, expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed table, then three random phases, each
  // with its own cache type / CPU ID setting loaded while the block is idle.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    row_t  rows [$];
    tag_t  no_tag;
    bit    burst;
    int    phase;
    logic [31:0] ctx_val;
    no_tag  = '0;
    ctx_val = $urandom;
    reset_shadow();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ID words at opposite extremes for the directed part
    load_id_regs(32'h0, 32'hFFFF_FFFF);

    //                 op        p  crn op1 crm op2 wdata           typed data          hit
    // identification: main ID, both cfg words, last feature word
    rows.push_back(mk_row(OP_READ,  1, 0,  0,  0,  0, 32'h0,          1, 32'h410F_B024, 1));
    rows.push_back(mk_row(OP_READ,  1, 0,  0,  0,  1, 32'h0,          1, 32'h0,         1));
    rows.push_back(mk_row(OP_READ,  1, 0,  0,  0,  5, 32'h0,          1, 32'hFFFF_FFFF, 1));
    rows.push_back(mk_row(OP_READ,  1, 0,  0,  2,  4, 32'h0,          1, 32'h0000_0141, 1));
    // architected reset values
    rows.push_back(mk_row(OP_READ,  1, 1,  0,  0,  0, 32'h0,          1, 32'h0005_4078, 1));
    rows.push_back(mk_row(OP_READ,  1, 1,  0,  0,  1, 32'h0,          1, 32'h0000_000F, 1));
    rows.push_back(mk_row(OP_READ,  1, 9,  0,  0,  0, 32'h0,          1, 32'hFFFF_FFF0, 1));
    rows.push_back(mk_row(OP_READ,  1, 10, 0,  2,  0, 32'h0,          1, 32'h0009_8AA4, 1));
    rows.push_back(mk_row(OP_READ,  1, 10, 0,  2,  1, 32'h0,          1, 32'h44E0_48E0, 1));
    // write all ones, read back; user mode can't see control
    rows.push_back(mk_row(OP_WRITE, 1, 1,  0,  0,  0, 32'hFFFF_FFFF,  1, 32'h0,         1));
    rows.push_back(mk_row(OP_READ,  1, 1,  0,  0,  0, 32'h0,          1, 32'hFFFF_FFFF, 1));
    rows.push_back(mk_row(OP_READ,  0, 1,  0,  0,  0, 32'h0,          1, 32'h0,         0));
    // thread URW from user; URO readable by user, writable only privileged
    rows.push_back(mk_row(OP_WRITE, 0, 13, 0,  0,  2, 32'hA5A5_A5A5,  1, 32'h0,         1));
    rows.push_back(mk_row(OP_READ,  0, 13, 0,  0,  2, 32'h0,          1, 32'hA5A5_A5A5, 1));
    rows.push_back(mk_row(OP_WRITE, 0, 13, 0,  0,  3, 32'h1234_5678,  1, 32'h0,         0));
    rows.push_back(mk_row(OP_WRITE, 1, 13, 0,  0,  3, 32'h8765_4321,  1, 32'h0,         1));
    rows.push_back(mk_row(OP_READ,  0, 13, 0,  0,  3, 32'h0,          1, 32'h8765_4321, 1));
    // context ID: Op1 ignored on privileged reads only, and only for 0/1/4
    rows.push_back(mk_row(OP_WRITE, 1, 13, 0,  0,  1, ctx_val,        0, 32'h0,         0));
    rows.push_back(mk_row(OP_READ,  1, 13, 7,  0,  1, 32'h0,          0, 32'h0,         0));
    rows.push_back(mk_row(OP_WRITE, 1, 13, 7,  0,  1, 32'h0,          1, 32'h0,         0));
    rows.push_back(mk_row(OP_READ,  1, 13, 7,  0,  2, 32'h0,          1, 32'h0,         0));
    // PA word reads as zero; the translation op itself is not there
    rows.push_back(mk_row(OP_READ,  1, 7,  0,  4,  0, 32'h0,          1, 32'h0,         1));
    rows.push_back(mk_row(OP_WRITE, 1, 7,  0,  4,  0, 32'h1,          1, 32'h0,         0));
    // user barrier ok, user cache op refused, TLB lockdown op accepted
    rows.push_back(mk_row(OP_WRITE, 0, 7,  0,  10, 4, 32'h0,          1, 32'h0,         1));
    rows.push_back(mk_row(OP_WRITE, 0, 7,  0,  5,  0, 32'h0,          1, 32'h0,         0));
    rows.push_back(mk_row(OP_WRITE, 1, 8,  0,  7,  3, 32'h0,          1, 32'h0,         1));
    // all selector fields at max: nothing there
    rows.push_back(mk_row(OP_READ,  1, 15, 7,  15, 7, 32'hFFFF_FFFF,  1, 32'h0,         0));

    foreach (rows[i]) issue_access(rows[i].beat, pick_gap(), rows[i].tag);
    drain();

    // Random phases; every 64 beats maybe a burst with no access-side gaps
    for (phase = 1; phase <= 3; phase++) begin
      case (phase)
        1:       load_id_regs(32'hFFFF_FFFF, 32'h0);
        default: load_id_regs($urandom, $urandom);
      endcase
      burst = 1'b0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 64 == 0) burst = ($urandom_range(0, 2) == 0);
        issue_access(random_access(), burst ? 0 : pick_gap(), no_tag);
      end
      drain();
    end

    $display("Covered %0d accesses (%0d reads, %0d writes, %0d user mode) under %0d ID settings.",
             n_reads + n_writes, n_reads, n_writes, n_user, n_settings);
    $display("%0d accesses recognized, %0d mismatches logged.", n_hits, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
